// ----- design/pfsh_pkg.sv -----
// Shared types and constants for the first-seen hash map.
// No dependencies; imported by every module of the block.
package pfsh_pkg;

  // Request: key to look up or insert, and the index to store if the key is new
  typedef struct packed {
    logic [63:0] key;
    logic [31:0] store_index;
  } in_t;

  // Result: stored index and outcome
  typedef struct packed {
    logic [31:0] first_index;
    logic [1:0]  status;
  } out_t;

  // Result status codes
  localparam logic [1:0] ST_NEW     = 2'd0;
  localparam logic [1:0] ST_PRESENT = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  // fmix64 finalizer constants
  localparam logic [63:0] MIX_C1    = 64'hff51afd7ed558ccd;
  localparam logic [63:0] MIX_C2    = 64'hc4ceb9fe1a85ec53;
  localparam int          MIX_SHIFT = 33;

endpackage

// ----- design/pfsh_mix.sv -----
// Iterative 64-bit fmix64 hash unit built around one shared 32x32 multiplier.
// Depends on pfsh_pkg for the mixing constants.
module pfsh_mix import pfsh_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [63:0] din,
  output logic        done,
  output logic [63:0] dout
);

  localparam logic [1:0] M_IDLE = 2'd0;
  localparam logic [1:0] M_MUL  = 2'd1;
  localparam logic [1:0] M_XS   = 2'd2;

  logic [1:0]  state_r, state_nxt;
  logic [1:0]  step_r, step_nxt;
  logic        sel_r, sel_nxt;
  logic        done_r, done_nxt;
  logic [63:0] v_r, v_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [63:0] prod_r, prod_nxt;
  logic [63:0] cst;
  logic [31:0] op_a, op_b;

  // Partial product operands: lo*lo, lo*hi, hi*lo (hi*hi falls off the top)
  always_comb begin
    cst = sel_r ? MIX_C2 : MIX_C1;
    case (step_r)
      2'd0: begin
        op_a = v_r[31:0];
        op_b = cst[31:0];
      end
      2'd1: begin
        op_a = v_r[31:0];
        op_b = cst[63:32];
      end
      default: begin
        op_a = v_r[63:32];
        op_b = cst[31:0];
      end
    endcase
    prod_nxt = op_a * op_b;
  end

  // Sequencer: xor-shift, multiply in four steps, xor-shift, repeat, xor-shift
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    sel_nxt   = sel_r;
    done_nxt  = 1'b0;
    v_nxt     = v_r;
    acc_nxt   = acc_r;
    unique case (state_r)
      M_IDLE: begin
        if (go) begin
          v_nxt     = din ^ (din >> MIX_SHIFT);
          step_nxt  = 2'd0;
          sel_nxt   = 1'b0;
          state_nxt = M_MUL;
        end
      end
      M_MUL: begin
        // accumulate the product registered in the previous step
        case (step_r)
          2'd0:    acc_nxt = acc_r;
          2'd1:    acc_nxt = prod_r;
          default: acc_nxt = acc_r + {prod_r[31:0], 32'd0};
        endcase
        step_nxt = step_r + 2'd1;
        if (step_r == 2'd3) begin
          state_nxt = M_XS;
        end
      end
      M_XS: begin
        v_nxt = acc_r ^ (acc_r >> MIX_SHIFT);
        if (!sel_r) begin
          sel_nxt   = 1'b1;
          step_nxt  = 2'd0;
          state_nxt = M_MUL;
        end else begin
          done_nxt  = 1'b1;
          state_nxt = M_IDLE;
        end
      end
      default: state_nxt = M_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
      step_r  <= 2'd0;
      sel_r   <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      sel_r   <= sel_nxt;
      done_r  <= done_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    v_r    <= v_nxt;
    acc_r  <= acc_nxt;
    prod_r <= prod_nxt;
  end

  assign done = done_r;
  assign dout = v_r;

endmodule

// ----- design/pointer_first_seen_hash_map_top.sv -----
// Top level of the first-seen hash map: slot memory, probe sequencer, result register.
// Depends on pfsh_pkg and pfsh_mix.
//
// Usage:
//   A request is taken when start is high and busy is low: in_data carries a 64-bit key
//   and the index to store if the key is new. Exactly one result follows on out_data,
//   held for one cycle with out_valid high; the receiver cannot stall it.
//   Status: new (index stored), present (index stored first returned), full.
//   A full table (half of CAPACITY used) answers full in the cycle after the request
//   and changes nothing. Otherwise the key is hashed by the fmix64 unit, which runs
//   its one 32x32 multiplier over two four-step products. Linear probing then
//   visits each slot with a read and then a compare through the single slot
//   memory port; the result appears with busy dropping in the same cycle, and
//   the next request can be taken in that same cycle. A new request is not taken
//   while the previous one is still being hashed or probed.
//   After reset the block zeroes every slot, valid bit, key and index, one slot per
//   cycle, with busy high.
//   CAPACITY must be a power of two; the block itself does not enforce it.
module pointer_first_seen_hash_map_top import pfsh_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_data,
  output logic out_valid,
  output out_t out_data
);

  localparam int IDXW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNTW = $clog2(CAPACITY / 2 + 1);
  localparam logic [IDXW-1:0] MASK     = IDXW'(CAPACITY - 1);
  localparam logic [IDXW-1:0] LAST     = IDXW'(CAPACITY - 1);
  localparam logic [CNTW-1:0] HALF_CAP = CNTW'(CAPACITY / 2);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_HASH  = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_CMP   = 3'd4;

  typedef struct packed {
    logic        valid;
    logic [63:0] key;
    logic [31:0] index;
  } slot_t;

  slot_t mem [CAPACITY];

  logic [2:0]      state_r, state_nxt;
  logic [IDXW-1:0] pos_r, pos_nxt;
  logic [IDXW-1:0] tries_r, tries_nxt;
  logic [CNTW-1:0] used_r, used_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_t            out_r, out_nxt;
  in_t             req_r, req_nxt;
  slot_t           rd_q_r;
  logic            mem_we;
  slot_t           mem_wd;
  logic            full;
  logic            mix_go;
  logic            mix_done;
  logic [63:0]     mix_dout;

  assign full   = (used_r >= HALF_CAP);
  assign mix_go = (state_r == S_IDLE) && start && !full;

  pfsh_mix u_mix (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (mix_go),
    .din   (in_data.key),
    .done  (mix_done),
    .dout  (mix_dout)
  );

  // Probe sequencer
  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    tries_nxt     = tries_r;
    used_nxt      = used_r;
    req_nxt       = req_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    mem_we        = 1'b0;
    mem_wd        = '0;
    unique case (state_r)
      S_CLEAR: begin
        mem_we  = 1'b1;
        pos_nxt = pos_r + 1'b1;
        if (pos_r == LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          if (full) begin
            out_valid_nxt       = 1'b1;
            out_nxt.first_index = 32'd0;
            out_nxt.status      = ST_FULL;
          end else begin
            req_nxt   = in_data;
            state_nxt = S_HASH;
          end
        end
      end
      S_HASH: begin
        if (mix_done) begin
          pos_nxt   = mix_dout[IDXW-1:0] & MASK;
          tries_nxt = '0;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (!rd_q_r.valid) begin
          // empty slot: insert
          mem_we              = 1'b1;
          mem_wd.valid        = 1'b1;
          mem_wd.key          = req_r.key;
          mem_wd.index        = req_r.store_index;
          used_nxt            = used_r + 1'b1;
          out_valid_nxt       = 1'b1;
          out_nxt.first_index = req_r.store_index;
          out_nxt.status      = ST_NEW;
          state_nxt           = S_IDLE;
        end else if (rd_q_r.key == req_r.key) begin
          out_valid_nxt       = 1'b1;
          out_nxt.first_index = rd_q_r.index;
          out_nxt.status      = ST_PRESENT;
          state_nxt           = S_IDLE;
        end else if (tries_r == LAST) begin
          // every slot visited without a match or a hole
          out_valid_nxt       = 1'b1;
          out_nxt.first_index = 32'd0;
          out_nxt.status      = ST_FULL;
          state_nxt           = S_IDLE;
        end else begin
          tries_nxt = tries_r + 1'b1;
          pos_nxt   = (pos_r + 1'b1) & MASK;
          state_nxt = S_READ;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      pos_r       <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    tries_r <= tries_nxt;
    req_r   <= req_nxt;
    out_r   <= out_nxt;
  end

  // Slot memory: one port, write and registered read at the probe position
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[pos_r] <= mem_wd;
    end
    rd_q_r <= mem[pos_r];
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- design/pfsh_checker.sv -----
// Port-level checker for the first-seen hash map, bound to the top level.
// Depends on pfsh_pkg for the status codes.
module pfsh_checker import pfsh_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input out_t out_data
);

  // Status is always one of the three defined codes
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status == ST_NEW || out_data.status == ST_PRESENT ||
                   out_data.status == ST_FULL))
    else $error("result with undefined status");

  // A full answer carries index zero
  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == ST_FULL) |-> (out_data.first_index == 32'd0))
    else $error("full result with nonzero index");

  // A result only follows an accepted request or a busy period
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(start && !busy) || $past(busy)))
    else $error("result without a pending request");

  // An accepted request either answers at once or keeps the block busy
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted request dropped");

endmodule

bind pointer_first_seen_hash_map_top pfsh_checker u_pfsh_checker (.*);
